// File: rtl/sdss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdss_pkg
// shared types, command codes and widths of the sparse/dense symbol set
// ----------------------------------------------------------------------------
package sdss_pkg;

    localparam int unsigned SYM_W             = 10;
    localparam int unsigned POS_W             = 11;
    localparam int unsigned CMD_W             = 3;
    localparam int unsigned MAX_SYMBOLS_DFLT  = 1024;
    localparam logic [POS_W-1:0] CAP_RESET    = 11'd1024;

    // item commands
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INCLUDE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LINK     = 3'd5;

    // dense read address source
    localparam logic [1:0] DS_POS_IN = 2'd0;
    localparam logic [1:0] DS_SPARSE = 2'd1;
    localparam logic [1:0] DS_WALK   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [SYM_W-1:0] symbol;
        logic [POS_W-1:0] position;
    } t_in;

    typedef struct packed {
        logic             member;
        logic [POS_W-1:0] set_size;
        logic [SYM_W-1:0] dense_value;
        logic             error;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic       latch;
        logic       clr_write;
        logic [1:0] dsel;
        logic       set_err;
        logic       set_member;
        logic       cap_value;
        logic       cap_p;
        logic       wr_dense_pos;
        logic       clr_count;
        logic       ins_write;
        logic       walk_start;
        logic       walk_chk;
        logic       walk_build;
        logic       set_count_pos;
        logic       load_out;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic             clr_last;
        logic             range_err;
        logic [CMD_W-1:0] cmd;
        logic             is_member;
        logic             full;
        logic             walk_done;
        logic             walk_bad;
        logic             out_free;
    } t_sts;

endpackage
`default_nettype wire

// File: rtl/sparse_dense_symbol_set.sv
`default_nettype none
// sequence: clear, write dense and read dense pass from accept through decode to the result
// register; include and contains add a dense check, link a check walk and then a build walk
// throughput: one item at a time, the next taken the cycle after the result loads;
// set by the sparse read then dense read chain and the link walk, one entry a cycle
// reset: synchronous, then a clearing pass over every address zeroes both
// memories while the input is held off; config writes are taken throughout
// ----------------------------------------------------------------------------
// sparse_dense_symbol_set
// set of small integer symbols with constant time clear (sparse map plus
// dense list), one result item per input item
// ----------------------------------------------------------------------------
module sparse_dense_symbol_set
    import sdss_pkg::*;
#(
    parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DFLT
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in              i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out                  o_out,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [POS_W-1:0] i_cfg_data
);

    t_ctl ctl;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    sdss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    sdss_datapath #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

// File: rtl/sdss_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdss_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module sdss_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/sdss_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdss_datapath
// sparse map and dense list memories, member count, walk counter,
// result and output registers
// ----------------------------------------------------------------------------
module sdss_datapath
    import sdss_pkg::*;
#(
    parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DFLT
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_in              i_in,
    input  wire logic             i_cfg_we,
    input  wire logic [POS_W-1:0] i_cfg_data,
    input  wire t_ctl             i_ctl,
    output t_sts                  o_sts,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output t_out                  o_out
);

    localparam int unsigned AW = $clog2(MAX_SYMBOLS);
    localparam int unsigned CW = ($clog2(MAX_SYMBOLS + 1) > POS_W) ?
                                 $clog2(MAX_SYMBOLS + 1) : POS_W;
    localparam logic [CW-1:0] CAP_MAX = CW'(MAX_SYMBOLS);
    localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_SYMBOLS - 1);

    logic [POS_W-1:0] r_capacity;
    logic [POS_W-1:0] r_count;
    logic [CMD_W-1:0] r_cmd;
    logic [SYM_W-1:0] r_sym;
    logic [POS_W-1:0] r_pos;
    logic [AW-1:0]    r_p;
    logic [AW-1:0]    r_clr_addr;
    logic [POS_W-1:0] r_k;
    logic [POS_W-1:0] r_kd;
    logic             r_kv;
    logic             r_bad;
    logic             r_member;
    logic [SYM_W-1:0] r_value;
    logic             r_err;

    logic [CW-1:0]    cap_eff;
    logic [CW-1:0]    sym_x;
    logic [CW-1:0]    pos_x;
    logic             range_err;
    logic             walk_act;
    logic             walk_issue;

    logic             sp_we;
    logic [AW-1:0]    sp_waddr;
    logic [AW-1:0]    sp_wdata;
    logic [AW-1:0]    sp_rdata;
    logic             dn_we;
    logic [AW-1:0]    dn_waddr;
    logic [SYM_W-1:0] dn_wdata;
    logic [AW-1:0]    dn_raddr;
    logic [SYM_W-1:0] dn_rdata;

    assign cap_eff = (CW'(r_capacity) < CAP_MAX) ? CW'(r_capacity) : CAP_MAX;
    assign sym_x   = CW'(r_sym);
    assign pos_x   = CW'(r_pos);

    always_comb begin
        unique case (r_cmd)
            CMD_INCLUDE, CMD_CONTAINS: range_err = (sym_x >= cap_eff);
            CMD_WRITE:                 range_err = (pos_x >= cap_eff) || (sym_x >= cap_eff);
            CMD_READ, CMD_LINK:        range_err = (pos_x >= cap_eff);
            default:                   range_err = 1'b0;
        endcase
    end

    assign walk_act   = i_ctl.walk_chk || i_ctl.walk_build;
    assign walk_issue = walk_act && (r_k < r_pos);

    // sparse map port
    always_comb begin
        sp_we    = 1'b0;
        sp_waddr = r_clr_addr;
        sp_wdata = '0;
        if (i_ctl.clr_write) begin
            sp_we = 1'b1;
        end else if (i_ctl.ins_write) begin
            sp_we    = 1'b1;
            sp_waddr = AW'(r_sym);
            sp_wdata = AW'(r_count);
        end else if (i_ctl.walk_build && r_kv) begin
            sp_we    = 1'b1;
            sp_waddr = AW'(dn_rdata);
            sp_wdata = AW'(r_kd);
        end
    end

    // dense list port
    always_comb begin
        dn_we    = 1'b0;
        dn_waddr = r_clr_addr;
        dn_wdata = '0;
        if (i_ctl.clr_write) begin
            dn_we = 1'b1;
        end else if (i_ctl.wr_dense_pos) begin
            dn_we    = 1'b1;
            dn_waddr = AW'(r_pos);
            dn_wdata = r_sym;
        end else if (i_ctl.ins_write) begin
            dn_we    = 1'b1;
            dn_waddr = AW'(r_count);
            dn_wdata = r_sym;
        end
    end

    always_comb begin
        unique case (i_ctl.dsel)
            DS_SPARSE: dn_raddr = sp_rdata;
            DS_WALK:   dn_raddr = AW'(r_k);
            default:   dn_raddr = AW'(i_in.position);
        endcase
    end

    sdss_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_SYMBOLS)
    ) u_sparse (
        .i_clk   (i_clk),
        .i_we    (sp_we),
        .i_waddr (sp_waddr),
        .i_wdata (sp_wdata),
        .i_raddr (AW'(i_in.symbol)),
        .o_rdata (sp_rdata)
    );

    sdss_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_SYMBOLS)
    ) u_dense (
        .i_clk   (i_clk),
        .i_we    (dn_we),
        .i_waddr (dn_waddr),
        .i_wdata (dn_wdata),
        .i_raddr (dn_raddr),
        .o_rdata (dn_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_count     <= '0;
            r_clr_addr  <= '0;
            r_k         <= '0;
            r_kv        <= 1'b0;
            r_bad       <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (i_ctl.clr_write) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_ctl.clr_count) begin
                r_count <= '0;
            end else if (i_ctl.set_count_pos) begin
                r_count <= r_pos;
            end else if (i_ctl.ins_write) begin
                r_count <= r_count + 1'b1;
            end
            // walk over the first position dense entries, one read a cycle
            if (i_ctl.walk_start) begin
                r_k   <= '0;
                r_kv  <= 1'b0;
                r_bad <= 1'b0;
            end else if (walk_act) begin
                r_kv <= walk_issue;
                if (walk_issue) begin
                    r_k <= r_k + 1'b1;
                end
                if (i_ctl.walk_chk && r_kv && (CW'(dn_rdata) >= cap_eff)) begin
                    r_bad <= 1'b1;
                end
            end
            if (i_ctl.load_out) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd    <= i_in.command;
            r_sym    <= i_in.symbol;
            r_pos    <= i_in.position;
            r_member <= 1'b0;
            r_value  <= '0;
            r_err    <= 1'b0;
        end else begin
            if (i_ctl.set_err) begin
                r_err <= 1'b1;
            end
            if (i_ctl.set_member) begin
                r_member <= 1'b1;
            end
            if (i_ctl.cap_value) begin
                r_value <= dn_rdata;
            end
        end
        if (i_ctl.cap_p) begin
            r_p <= sp_rdata;
        end
        if (walk_issue) begin
            r_kd <= r_k;
        end
        if (i_ctl.load_out) begin
            o_out.member      <= r_member;
            o_out.set_size    <= r_count;
            o_out.dense_value <= r_value;
            o_out.error       <= r_err;
        end
    end

    assign o_sts.clr_last  = (r_clr_addr == ADDR_LAST);
    assign o_sts.range_err = range_err;
    assign o_sts.cmd       = r_cmd;
    assign o_sts.is_member = (CW'(r_p) < CW'(r_count)) && (dn_rdata == r_sym);
    assign o_sts.full      = (CW'(r_count) >= cap_eff);
    assign o_sts.walk_done = (r_k >= r_pos) && !r_kv;
    assign o_sts.walk_bad  = r_bad;
    assign o_sts.out_free  = !o_out_valid || i_out_ready;

    // member count never runs past the memory depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_count) <= CAP_MAX)
        else $error("member count beyond memory depth");

    a_ins_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.ins_write |=> r_count == $past(r_count) + 1'b1)
        else $error("include did not grow the set by one");

    a_link_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.set_count_pos |-> !r_bad && !r_kv)
        else $error("link committed with a bad or pending dense entry");

endmodule
`default_nettype wire

// File: rtl/sdss_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdss_ctrl
// state machine sequencing the memory clear, each command and the link walk
// ----------------------------------------------------------------------------
module sdss_ctrl
    import sdss_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_ctl      o_ctl
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_DCHK   = 4'd3;
    localparam logic [3:0] S_LCHK   = 4'd4;
    localparam logic [3:0] S_LBUILD = 4'd5;
    localparam logic [3:0] S_OUT    = 4'd6;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_ctl      = '0;
        o_ctl.dsel = DS_POS_IN;
        unique case (r_state)
            S_CLEAR: begin
                o_ctl.clr_write = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctl.latch = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_OUT;
                if (i_sts.range_err) begin
                    o_ctl.set_err = 1'b1;
                end else begin
                    unique case (i_sts.cmd)
                        CMD_CLEAR:    o_ctl.clr_count    = 1'b1;
                        CMD_WRITE:    o_ctl.wr_dense_pos = 1'b1;
                        CMD_READ:     o_ctl.cap_value    = 1'b1;
                        CMD_INCLUDE, CMD_CONTAINS: begin
                            // sparse entry is out, fetch the dense entry it points at
                            o_ctl.dsel  = DS_SPARSE;
                            o_ctl.cap_p = 1'b1;
                            n_state     = S_DCHK;
                        end
                        CMD_LINK: begin
                            o_ctl.walk_start = 1'b1;
                            n_state          = S_LCHK;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_DCHK: begin
                n_state = S_OUT;
                priority if (i_sts.is_member) begin
                    o_ctl.set_member = 1'b1;
                end else if (i_sts.cmd == CMD_INCLUDE) begin
                    if (i_sts.full) begin
                        o_ctl.set_err = 1'b1;
                    end else begin
                        o_ctl.ins_write  = 1'b1;
                        o_ctl.set_member = 1'b1;
                    end
                end else begin
                    // contains of a symbol that is not a member
                    o_ctl.set_member = 1'b0;
                end
            end
            S_LCHK: begin
                o_ctl.dsel     = DS_WALK;
                o_ctl.walk_chk = 1'b1;
                if (i_sts.walk_done) begin
                    o_ctl.walk_chk = 1'b0;
                    if (i_sts.walk_bad) begin
                        o_ctl.set_err = 1'b1;
                        n_state       = S_OUT;
                    end else begin
                        o_ctl.set_count_pos = 1'b1;
                        o_ctl.walk_start    = 1'b1;
                        n_state             = S_LBUILD;
                    end
                end
            end
            S_LBUILD: begin
                o_ctl.dsel       = DS_WALK;
                o_ctl.walk_build = 1'b1;
                if (i_sts.walk_done) begin
                    o_ctl.walk_build = 1'b0;
                    n_state          = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> r_state == S_DECODE)
        else $error("accepted item not decoded");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load_out |-> i_sts.out_free)
        else $error("result loaded over an untaken result");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && i_sts.clr_last) |=> o_in_ready)
        else $error("clear pass finished but input not opened");

endmodule
`default_nettype wire

// File: bench/sparse_dense_symbol_set_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_dense_symbol_set_checker
// watches the item, result and capacity channels, keeps its own sparse map,
// dense list and member count, and compares every result with its prediction
// ----------------------------------------------------------------------------
module sparse_dense_symbol_set_checker
    import sdss_pkg::*;
#(
    parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DFLT
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_ready,
    input  wire t_in              i_in,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_ready,
    input  wire t_out             i_out,
    input  wire logic             i_cfg_valid,
    input  wire logic             i_cfg_ready,
    input  wire logic [POS_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_outstanding
);

    logic [POS_W-1:0] capacity;
    logic [POS_W-1:0] member_count;
    logic [SYM_W-1:0] sparse_map [0:MAX_SYMBOLS-1];
    logic [SYM_W-1:0] dense_list [0:MAX_SYMBOLS-1];
    t_out             expected_results [$];
    int               fails = 0;

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    function automatic logic is_in_set(input logic [SYM_W-1:0] sym);
        logic [SYM_W-1:0] slot;
        slot = sparse_map[sym];
        return (slot < member_count) && (dense_list[slot] == sym);
    endfunction

    // updates the set state and returns the result this item must give
    function automatic t_out apply_command(input t_in it);
        t_out             res;
        logic [POS_W-1:0] cap;
        logic             bad_entry;
        int               k;
        res = '0;
        cap = (capacity > MAX_SYMBOLS) ? POS_W'(MAX_SYMBOLS) : capacity;
        case (it.command)
            CMD_CLEAR: begin
                member_count = '0;
            end
            CMD_INCLUDE: begin
                if (it.symbol >= cap) begin
                    res.error = 1'b1;
                end else if (is_in_set(it.symbol)) begin
                    res.member = 1'b1;
                end else if (member_count >= cap) begin
                    // set full, or capacity lowered below the present size
                    res.error = 1'b1;
                end else begin
                    dense_list[member_count[SYM_W-1:0]] = it.symbol;
                    sparse_map[it.symbol] = member_count[SYM_W-1:0];
                    member_count = member_count + 1'b1;
                    res.member = 1'b1;
                end
            end
            CMD_CONTAINS: begin
                if (it.symbol >= cap)
                    res.error = 1'b1;
                else
                    res.member = is_in_set(it.symbol);
            end
            CMD_WRITE: begin
                if (it.position >= cap || it.symbol >= cap)
                    res.error = 1'b1;
                else
                    dense_list[it.position[SYM_W-1:0]] = it.symbol;
            end
            CMD_READ: begin
                if (it.position >= cap)
                    res.error = 1'b1;
                else
                    res.dense_value = dense_list[it.position[SYM_W-1:0]];
            end
            CMD_LINK: begin
                if (it.position >= cap) begin
                    res.error = 1'b1;
                end else begin
                    bad_entry = 1'b0;
                    for (k = 0; k < it.position; k++)
                        if (dense_list[k] >= cap)
                            bad_entry = 1'b1;
                    if (bad_entry) begin
                        res.error = 1'b1;
                    end else begin
                        member_count = it.position;
                        for (k = 0; k < it.position; k++)
                            sparse_map[dense_list[k]] = SYM_W'(k);
                    end
                end
            end
            default: begin
            end
        endcase
        res.set_size = member_count;
        return res;
    endfunction

    function automatic bit field_ok(input string name, input int unsigned want_v,
                                    input int unsigned got_v);
        if (want_v != got_v)
            $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
        return want_v == got_v;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out want;
        int   k;
        if (!i_rst_n) begin
            capacity     = CAP_RESET;
            member_count = '0;
            for (k = 0; k < MAX_SYMBOLS; k++) begin
                sparse_map[k] = '0;
                dense_list[k] = '0;
            end
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                capacity = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: expected no result, actual member %0d size %0d value %0d error %0d",
                             $time, i_out.member, i_out.set_size, i_out.dense_value,
                             i_out.error);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (!(field_ok("member", want.member, i_out.member)
                          & field_ok("set_size", want.set_size, i_out.set_size)
                          & field_ok("dense_value", want.dense_value, i_out.dense_value)
                          & field_ok("error", want.error, i_out.error)))
                        fails++;
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(apply_command(i_in));
        end
        o_fail_count  <= fails;
        o_outstanding <= expected_results.size();
    end

endmodule

// File: bench/sparse_dense_symbol_set_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_dense_symbol_set_tb
// drives directed and random set commands through several capacity settings
// with bursty items and a stalling receiver; the checker predicts each result
// ----------------------------------------------------------------------------
module sparse_dense_symbol_set_tb;
    import sdss_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int unsigned TAIL_CYCLES = 2100;
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef enum int { READY_ALWAYS, READY_COIN, READY_SEVENTH, READY_SPARSE } t_ready_mode;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_in              in_item   = '0;
    logic             out_ready = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [POS_W-1:0] cfg_data  = '0;
    logic             in_ready;
    logic             out_valid;
    t_out             out_item;
    logic             cfg_ready;
    int               fail_count;
    int               outstanding;

    int unsigned      cur_cap    = 1024;
    int               burst_left = 0;
    logic [SYM_W-1:0] recent_syms [$];

    sparse_dense_symbol_set uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    sparse_dense_symbol_set_checker result_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in          (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out         (out_item),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL sparse_dense_symbol_set");
        $finish;
    end

    // receiver: stretches of differing stall behaviour
    initial begin : out_stall_pattern
        t_ready_mode mode;
        int          span;
        int          phase;
        forever begin
            mode = t_ready_mode'($urandom_range(0, 3));
            span = $urandom_range(4, 80);
            for (phase = 0; phase < span; phase++) begin
                @(negedge clk);
                case (mode)
                    READY_ALWAYS:  out_ready <= 1'b1;
                    READY_COIN:    out_ready <= 1'($urandom_range(0, 1));
                    READY_SEVENTH: out_ready <= (phase % 7 == 6);
                    default:       out_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    function automatic t_in mk(input logic [CMD_W-1:0] cmd, input int unsigned sym,
                               input int unsigned pos);
        t_in it;
        it.command  = cmd;
        it.symbol   = SYM_W'(sym);
        it.position = POS_W'(pos);
        return it;
    endfunction

    // holds valid across a burst, drops it only for a gap
    task automatic issue(input t_in it);
        int gap;
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                3:       gap = $urandom_range(1, 40);
                default: gap = $urandom_range(1, 10);
            endcase
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic wait_all_results;
        if (in_valid)
            in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_capacity(input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_data  <= POS_W'(value);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_cap = (value > MAX_SYMBOLS_DFLT) ? MAX_SYMBOLS_DFLT : value;
    endtask

    function automatic int unsigned pick_symbol;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (cur_cap == 0 || r < 5)
            return $urandom_range(0, 1023);
        if (r < 40 && recent_syms.size() > 0)
            return recent_syms[$urandom_range(0, recent_syms.size() - 1)];
        return $urandom_range(0, cur_cap - 1);
    endfunction

    // low positions most of the time so that links find written entries
    function automatic int unsigned pick_position;
        int unsigned r;
        int unsigned lim;
        r   = $urandom_range(0, 99);
        lim = (cur_cap < 32) ? cur_cap : 32;
        if (cur_cap == 0 || r < 5)
            return $urandom_range(0, 2047);
        if (r < 55)
            return $urandom_range(0, lim - 1);
        return $urandom_range(0, cur_cap - 1);
    endfunction

    // link walks are slow, so counts stay short but for a few
    function automatic int unsigned pick_count;
        int unsigned r;
        int unsigned lim;
        r   = $urandom_range(0, 99);
        lim = (cur_cap < 21) ? cur_cap : 21;
        if (cur_cap == 0 || r < 4)
            return $urandom_range(0, 2047);
        if (r < 7)
            return $urandom_range(0, cur_cap - 1);
        return $urandom_range(0, lim - 1);
    endfunction

    function automatic t_in random_item;
        t_in         it;
        int unsigned r;
        r  = $urandom_range(0, 99);
        it = mk(CMD_INCLUDE, pick_symbol(), $urandom_range(0, 2047));
        if (r < 3)
            it.command = CMD_CLEAR;
        else if (r < 35)
            it.command = CMD_INCLUDE;
        else if (r < 60)
            it.command = CMD_CONTAINS;
        else if (r < 72)
            it = mk(CMD_WRITE, pick_symbol(), pick_position());
        else if (r < 84)
            it = mk(CMD_READ, $urandom_range(0, 1023), pick_position());
        else if (r < 94)
            it = mk(CMD_LINK, $urandom_range(0, 1023), pick_count());
        else if (r < 97)
            it.command = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
        else
            it.symbol = SYM_W'($urandom_range(0, 1023));
        if (it.command == CMD_INCLUDE) begin
            recent_syms.push_back(it.symbol);
            if (recent_syms.size() > 16)
                void'(recent_syms.pop_front());
        end
        return it;
    endfunction

    task automatic run_phase(input int unsigned cap, input int count);
        int i;
        wait_all_results();
        write_capacity(cap);
        for (i = 0; i < count; i++) begin
            issue(random_item());
            if ($urandom_range(0, 99) == 0)
                wait_all_results();
        end
    endtask

    initial begin : stimulus
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_capacity(1024);
        issue(mk(CMD_CONTAINS, 5, 0));
        issue(mk(CMD_INCLUDE, 0, 0));
        issue(mk(CMD_INCLUDE, 1023, 0));
        issue(mk(CMD_INCLUDE, 0, 0));
        issue(mk(CMD_CONTAINS, 1023, 0));
        issue(mk(CMD_READ, 0, 0));
        issue(mk(CMD_READ, 0, 1023));
        issue(mk(CMD_READ, 0, 1024));
        issue(mk(CMD_WRITE, 1023, 1023));
        issue(mk(CMD_WRITE, 0, 2047));
        issue(mk(CMD_LINK, 0, 2));
        issue(mk(CMD_LINK, 0, 1024));
        issue(mk(CMD_LINK, 0, 0));
        issue(mk(CMD_INCLUDE, 7, 0));
        // clear only drops the count, old entries must not look like members
        issue(mk(CMD_CLEAR, 0, 0));
        issue(mk(CMD_CONTAINS, 7, 0));
        issue(mk(CMD_SPARE_LO, 1023, 2047));
        issue(mk(CMD_SPARE_HI, 1023, 2047));
        issue(mk(CMD_INCLUDE, 10, 0));
        issue(mk(CMD_INCLUDE, 11, 0));
        issue(mk(CMD_INCLUDE, 12, 0));

        // capacity now below the size: full set, and dense entries out of range
        wait_all_results();
        write_capacity(2);
        issue(mk(CMD_INCLUDE, 0, 0));
        issue(mk(CMD_INCLUDE, 13, 0));
        issue(mk(CMD_WRITE, 5, 1));
        issue(mk(CMD_WRITE, 1, 1));
        issue(mk(CMD_LINK, 0, 1));
        issue(mk(CMD_CONTAINS, 1, 0));

        run_phase(1024, 320);
        run_phase(17, 150);
        run_phase(1, 60);
        run_phase(2047, 180);
        run_phase(2, 60);
        run_phase(0, 20);
        run_phase(300, 180);
        run_phase(1025, 100);
        run_phase(64, 150);

        wait_all_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS sparse_dense_symbol_set");
        else
            $display("FAIL sparse_dense_symbol_set");
        $finish;
    end

endmodule
